// ===== sv/byte_stream_rule_substitution_top_macros.svh =====
// assertion macros for the byte stream rule substitution block
`ifndef BYTE_STREAM_RULE_SUBSTITUTION_TOP_MACROS_SVH
`define BYTE_STREAM_RULE_SUBSTITUTION_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BSRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BSRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BSRS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BSRS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/bsrs_pkg.sv =====
// shared types and constants of the byte stream rule substitution block
package bsrs_pkg;
  localparam int RULE_SLOTS_DEF = 4;
  localparam int MAX_LEN_DEF = 4;
  localparam int COUNT_BITS_DEF = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam int OUT_COUNT_BITS = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RULE_COUNT = 3'd0,
    REG_MATCH_LOW = 3'd1,
    REG_MATCH_HIGH = 3'd2,
    REG_REPL_LOW = 3'd3,
    REG_REPL_HIGH = 3'd4,
    REG_MATCH_LEN = 3'd5,
    REG_REPL_LEN = 3'd6,
    REG_DST_LIMIT = 3'd7
  } reg_idx_t;

  // queue entry between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } src_entry_t;

  // result item
  typedef struct packed {
    logic [15:0] bytes_written;
    logic [15:0] bytes_consumed;
    logic        stopped_early;
    logic        run_end;
    logic        byte_valid;
    logic [7:0]  out_byte;
  } result_t;
endpackage

// ===== sv/bsrs_front.sv =====
// input stage and two entry queue between intake and rule engine
module bsrs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bsrs_pkg::src_entry_t in_entry,
  output logic                q_valid,
  input  logic                q_ready,
  output bsrs_pkg::src_entry_t q_entry
);
  import bsrs_pkg::*;

  src_entry_t slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_entry = slot[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  // queue pointers and storage
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= in_entry;
        wr_ptr <= ~wr_ptr;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== sv/bsrs_back.sv =====
// rule engine: lookahead window, rule matching, byte emission, counts
module bsrs_back #(
  parameter int RULE_SLOTS = bsrs_pkg::RULE_SLOTS_DEF,
  parameter int MAX_LEN = bsrs_pkg::MAX_LEN_DEF,
  parameter int COUNT_BITS = bsrs_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_idx,
  input  logic [63:0]          cfg_data,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  bsrs_pkg::src_entry_t q_entry,
  output logic                 res_valid,
  input  logic                 res_ready,
  output bsrs_pkg::result_t    res_data,
  output logic                 busy
);
  import bsrs_pkg::*;

  localparam int FILL_BITS = $clog2(MAX_LEN + 1);
  localparam int POS_BITS = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CMP_BITS = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration registers
  logic [2:0]  rule_count;
  logic [63:0] match_lo, match_hi, repl_lo, repl_hi;
  logic [11:0] match_len, repl_len;
  logic [15:0] dst_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0; match_lo <= '0; match_hi <= '0; repl_lo <= '0;
      repl_hi <= '0; match_len <= '0; repl_len <= '0; dst_limit <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_RULE_COUNT: rule_count <= cfg_data[2:0];
        REG_MATCH_LOW:  match_lo <= cfg_data;
        REG_MATCH_HIGH: match_hi <= cfg_data;
        REG_REPL_LOW:   repl_lo <= cfg_data;
        REG_REPL_HIGH:  repl_hi <= cfg_data;
        REG_MATCH_LEN:  match_len <= cfg_data[11:0];
        REG_REPL_LEN:   repl_len <= cfg_data[11:0];
        REG_DST_LIMIT:  dst_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stream state
  logic [7:0]            win [MAX_LEN];
  logic [FILL_BITS-1:0]  fill;
  logic [COUNT_BITS-1:0] consumed, written;
  logic                  halted;
  logic                  draining;    // final byte seen, flushing window
  // replacement emission in progress
  logic                  emitting;
  logic [2:0]            emit_pos, emit_len;
  logic [1:0]            emit_rule;
  logic [2:0]            emit_ml;
  // output register with one pending result
  logic                  ovalid;
  result_t               oreg;
  // last data result of the final request, held so the counts can ride on it
  logic                  pend_valid;
  result_t               pend;

  logic out_free;
  assign out_free = !ovalid || res_ready;
  assign res_valid = ovalid;
  assign res_data = oreg;
  assign busy = ovalid || draining || emitting || q_valid;

  function automatic logic [7:0] rbyte(logic [63:0] lo, logic [63:0] hi,
                                       logic [1:0] r, logic [2:0] k);
    logic [63:0] w;
    logic [5:0]  sh;
    w = r[1] ? hi : lo;
    sh = {r[0], k[1:0], 3'b000};
    return 8'(w >> sh);
  endfunction

  // rule match over the window, first rule wins
  logic       hit;
  logic [1:0] hit_rule;
  logic [2:0] hit_ml, hit_rl;
  always_comb begin
    logic [2:0] nr;
    logic [2:0] ml, rl;
    logic       eq;
    hit = 1'b0; hit_rule = '0; hit_ml = '0; hit_rl = '0;
    nr = (rule_count > 3'(RULE_SLOTS)) ? 3'(RULE_SLOTS) : rule_count;
    for (int r = 0; r < RULE_SLOTS; r++) begin
      ml = match_len[3*r +: 3];
      rl = repl_len[3*r +: 3];
      eq = (3'(r) < nr) && ml != 0 && rl != 0 && ml <= 3'(MAX_LEN)
           && rl <= 3'(MAX_LEN) && {1'b0, ml} <= 4'(fill);
      for (int k = 0; k < MAX_LEN; k++)
        if (3'(k) < ml && win[k] != rbyte(match_lo, match_hi, 2'(r), 3'(k)))
          eq = 1'b0;
      if (eq && !hit) begin
        hit = 1'b1; hit_rule = 2'(r); hit_ml = ml; hit_rl = rl;
      end
    end
  end

  // decide: process a position when window is full or draining
  logic need_proc, at_limit, no_fit;
  logic [CMP_BITS-1:0] wr_plus;
  assign need_proc = !halted && !emitting &&
                     ((fill == FILL_BITS'(MAX_LEN)) || (draining && fill != 0));
  assign wr_plus = CMP_BITS'(written) + CMP_BITS'(hit_rl);
  assign at_limit = CMP_BITS'(written) >= CMP_BITS'(dst_limit);
  assign no_fit = wr_plus > CMP_BITS'(dst_limit);

  // stream done: draining with nothing left to do
  logic finish;
  assign finish = draining && !emitting && (halted || fill == 0);

  // accept a byte when not processing, emitting or draining
  assign q_ready = !draining && !emitting && !need_proc;

  // actions of this cycle
  logic acc, put_ok, do_emit, do_proc, do_halt, do_hit, do_copy, gen_now, do_fin;
  logic emit_done, load_o;
  assign acc = q_valid && q_ready;
  assign put_ok = draining ? (!pend_valid || out_free) : out_free;
  assign do_emit = emitting && put_ok;
  assign do_proc = need_proc && put_ok;
  assign do_halt = do_proc && (at_limit || (hit && no_fit));
  assign do_hit = do_proc && !do_halt && hit;
  assign do_copy = do_proc && !do_halt && !hit;
  assign gen_now = do_emit || do_copy;
  assign do_fin = finish && out_free;
  assign emit_done = (emit_pos + 3'd1 == emit_len);
  assign load_o = do_fin || (gen_now && (!draining || pend_valid));

  // data result produced this cycle
  result_t gen_res;
  always_comb begin
    gen_res = '0;
    gen_res.byte_valid = 1'b1;
    gen_res.out_byte = emitting ? rbyte(repl_lo, repl_hi, emit_rule, emit_pos) : win[0];
  end

  // next output register contents
  result_t o_next;
  always_comb begin
    o_next = gen_res;
    if (do_fin) begin
      o_next = pend_valid ? pend : '0;
      o_next.run_end = 1'b1;
      o_next.bytes_consumed = 16'(consumed);
      o_next.bytes_written = 16'(written);
      o_next.stopped_early = halted;
    end else if (draining) begin
      o_next = pend;
    end
  end

  function automatic logic [COUNT_BITS-1:0] sat_add(logic [COUNT_BITS-1:0] a,
                                                    logic [2:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + (COUNT_BITS+1)'(b);
    return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  // output register and final result holding stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (load_o) begin
        ovalid <= 1'b1;
        oreg <= o_next;
      end else if (res_ready) begin
        ovalid <= 1'b0;
      end
      if (do_fin) begin
        pend_valid <= 1'b0;
      end else if (gen_now && draining) begin
        pend_valid <= 1'b1;
      end
      if (gen_now && draining) pend <= gen_res;
    end
  end

  // window, counts and emission sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0; consumed <= '0; written <= '0; halted <= 1'b0;
      draining <= 1'b0; emitting <= 1'b0;
      emit_pos <= '0; emit_len <= '0; emit_rule <= '0; emit_ml <= '0;
    end else begin
      if (acc) begin
        if (!halted && fill < FILL_BITS'(MAX_LEN)) begin
          win[fill[POS_BITS-1:0]] <= q_entry.data;
          fill <= fill + FILL_BITS'(1);
        end
        if (q_entry.last) draining <= 1'b1;
      end else if (do_emit) begin
        // one replacement byte per cycle while the output can take it
        written <= sat_add(written, 3'd1);
        emit_pos <= emit_pos + 3'd1;
        if (emit_done) begin
          emitting <= 1'b0;
          for (int i = 0; i < MAX_LEN; i++)
            if (i + int'(emit_ml) < MAX_LEN) win[i] <= win[i + int'(emit_ml)];
          fill <= fill - FILL_BITS'(emit_ml);
          consumed <= sat_add(consumed, emit_ml);
        end
      end else if (do_halt) begin
        halted <= 1'b1;
      end else if (do_hit) begin
        emitting <= 1'b1; emit_pos <= '0; emit_len <= hit_rl;
        emit_rule <= hit_rule; emit_ml <= hit_ml;
      end else if (do_copy) begin
        for (int i = 0; i + 1 < MAX_LEN; i++) win[i] <= win[i + 1];
        fill <= fill - FILL_BITS'(1);
        consumed <= sat_add(consumed, 3'd1);
        written <= sat_add(written, 3'd1);
      end else if (do_fin) begin
        // stream ends, state returns to zero
        fill <= '0; consumed <= '0; written <= '0; halted <= 1'b0;
        draining <= 1'b0;
      end
    end
  end
endmodule

// ===== sv/byte_stream_rule_substitution_top.sv =====
// top level of the byte stream rule substitution block
//  channel   dir  handshake           payload
//  s_axis    in   tvalid/tready       tdata=src_byte, tlast=src_last
//  m_axis    out  tvalid/tready       tdata=out_byte,counts; tuser=flags
//  cfg       in   cfg_we              cfg_idx, cfg_data
// a source request is registered in the queue, then written into the window
// with the window full a position is either copied, or a rule hit is decided and its
// replacement bytes are then emitted in order; no source byte is taken meanwhile
// on the final request the last data result is held one stage so the counts ride on it
// rst is synchronous; a stalled output holds the engine, the queue takes two more requests
`include "byte_stream_rule_substitution_top_macros.svh"
module byte_stream_rule_substitution_top #(
  parameter int RULE_SLOTS = bsrs_pkg::RULE_SLOTS_DEF,
  parameter int MAX_LEN = bsrs_pkg::MAX_LEN_DEF,
  parameter int COUNT_BITS = bsrs_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // src_byte
  input  logic        s_axis_tlast,   // src_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_byte, bytes_consumed, bytes_written
  output logic        m_axis_tlast,   // run_end
  output logic [1:0]  m_axis_tuser,   // byte_valid, stopped_early
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_data
);
  import bsrs_pkg::*;

  src_entry_t in_entry, q_entry;
  logic       q_valid, q_ready, busy;
  result_t    res;

  assign in_entry.data = s_axis_tdata;
  assign in_entry.last = s_axis_tlast;

  // intake queue
  bsrs_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_entry(in_entry), .q_valid(q_valid), .q_ready(q_ready), .q_entry(q_entry)
  );

  // rule engine
  bsrs_back #(.RULE_SLOTS(RULE_SLOTS), .MAX_LEN(MAX_LEN), .COUNT_BITS(COUNT_BITS))
  u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_entry(q_entry),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res),
    .busy(busy)
  );

  // result packing
  assign m_axis_tdata = {res.bytes_written, res.bytes_consumed, res.out_byte};
  assign m_axis_tlast = res.run_end;
  assign m_axis_tuser = {res.stopped_early, res.byte_valid};

  // checks
  `BSRS_ASSERT_IMPL(a_status_zero, clk, rst, m_axis_tvalid && !m_axis_tuser[0],
                    m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
  `BSRS_ASSERT_IMPL(a_early_end, clk, rst, m_axis_tvalid && m_axis_tuser[1],
                    m_axis_tlast)
  `BSRS_ASSERT_NEXT(a_busy, clk, rst, s_axis_tvalid && s_axis_tready, busy)
endmodule

// ===== verif/bsrs_checker.sv =====
// checker for the byte stream rule substitution block: predicts and compares results
`timescale 1ns / 100ps
module bsrs_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // src_byte
  input  logic        s_axis_tlast,   // src_last
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // out_byte, bytes_consumed, bytes_written
  input  logic        m_axis_tlast,   // run_end
  input  logic [1:0]  m_axis_tuser,   // byte_valid, stopped_early
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import bsrs_pkg::*;

  typedef struct {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_end;
    logic [15:0] consumed;
    logic [15:0] written;
    logic        stopped;
  } subst_out_t;

  subst_out_t  expected_q[$];

  // shadow registers
  logic [2:0]  rules_active;
  logic [63:0] pat_lo, pat_hi, rep_lo, rep_hi;
  logic [11:0] pat_lens, rep_lens;
  logic [15:0] cap;

  // shadow stream state
  logic [7:0]  win[4];
  int          win_fill;
  int          used_cnt;
  int          wrote_cnt;
  bit          stuck;
  int          emitted;

  function automatic logic [7:0] rule_byte(logic [63:0] lo, logic [63:0] hi, int r, int k);
    logic [63:0] w;
    w = (r < 2) ? lo : hi;
    return w[(r % 2) * 32 + k * 8 +: 8];
  endfunction

  task automatic push_byte(logic [7:0] b);
    subst_out_t e;
    e = '{b, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0};
    expected_q.push_back(e);
    emitted++;
  endtask

  task automatic shift_window(int k);
    if (k > win_fill) k = win_fill;
    for (int i = 0; i + k < win_fill; i++) win[i] = win[i + k];
    win_fill -= k;
    used_cnt += k;
    if (used_cnt > 65535) used_cnt = 65535;
  endtask

  // one source position at the head of the window
  task automatic substitute_head();
    int nr, ml, rl;
    bit eq;
    if (wrote_cnt >= cap) begin
      stuck = 1;
      return;
    end
    nr = (rules_active > 4) ? 4 : rules_active;
    for (int r = 0; r < nr; r++) begin
      ml = pat_lens[3*r +: 3];
      rl = rep_lens[3*r +: 3];
      if (ml == 0 || rl == 0 || ml > 4 || rl > 4 || ml > win_fill) continue;
      eq = 1;
      for (int k = 0; k < ml; k++)
        if (win[k] != rule_byte(pat_lo, pat_hi, r, k)) eq = 0;
      if (!eq) continue;
      if (wrote_cnt + rl > cap) begin
        stuck = 1;
        return;
      end
      for (int k = 0; k < rl; k++) push_byte(rule_byte(rep_lo, rep_hi, r, k));
      wrote_cnt += rl;
      shift_window(ml);
      return;
    end
    push_byte(win[0]);
    wrote_cnt += 1;
    shift_window(1);
  endtask

  task automatic take_request(logic [7:0] b, logic last);
    subst_out_t e;
    emitted = 0;
    if (!stuck && win_fill < 4) begin
      win[win_fill] = b;
      win_fill++;
    end
    if (!last) begin
      while (!stuck && win_fill >= 4) substitute_head();
      return;
    end
    while (!stuck && win_fill > 0) substitute_head();
    if (emitted == 0) begin
      e = '{8'd0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0};
      expected_q.push_back(e);
    end
    e = expected_q.pop_back();
    e.run_end = 1;
    e.consumed = used_cnt[15:0];
    e.written = wrote_cnt[15:0];
    e.stopped = stuck;
    expected_q.push_back(e);
    win_fill = 0;
    used_cnt = 0;
    wrote_cnt = 0;
    stuck = 0;
  endtask

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // watch config, requests and results
  always @(posedge clk) begin
    subst_out_t e;
    if (rst) begin
      rules_active <= 0;
      pat_lo <= 0; pat_hi <= 0; rep_lo <= 0; rep_hi <= 0;
      pat_lens <= 0; rep_lens <= 0; cap <= 0;
      win_fill = 0; used_cnt = 0; wrote_cnt = 0; stuck = 0;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_idx))
          REG_RULE_COUNT: rules_active <= cfg_data[2:0];
          REG_MATCH_LOW:  pat_lo <= cfg_data;
          REG_MATCH_HIGH: pat_hi <= cfg_data;
          REG_REPL_LOW:   rep_lo <= cfg_data;
          REG_REPL_HIGH:  rep_hi <= cfg_data;
          REG_MATCH_LEN:  pat_lens <= cfg_data[11:0];
          REG_REPL_LEN:   rep_lens <= cfg_data[11:0];
          REG_DST_LIMIT:  cap <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) take_request(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: out_byte %0h", m_axis_tdata[7:0]);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          check_field("out_byte", e.out_byte, m_axis_tdata[7:0]);
          check_field("byte_valid", e.byte_valid, m_axis_tuser[0]);
          check_field("run_end", e.run_end, m_axis_tlast);
          check_field("bytes_consumed", e.consumed, m_axis_tdata[23:8]);
          check_field("bytes_written", e.written, m_axis_tdata[39:24]);
          check_field("stopped_early", e.stopped, m_axis_tuser[1]);
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

// ===== verif/testbench.sv =====
// top of the byte stream rule substitution testbench: stimulus and verdict
`timescale 1ns / 100ps
module testbench;
  import bsrs_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 0;
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we = 0;
  logic [2:0]  cfg_idx = 0;
  logic [63:0] cfg_data = 0;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          hold_sink = 0;
  bit          sink_busy = 0;

  always #4 clk = ~clk;

  byte_stream_rule_substitution_top u_dut (.*);

  bsrs_checker u_chk (.*);

  // watchdog on cycles without any request or result
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // receiver: random stalls, a long hold-off on request
  initial begin
    int g;
    @(negedge clk);
    while (1) begin
      if (hold_sink) begin
        m_axis_tready <= 0;
        sink_busy = 1;
        repeat (300) @(negedge clk);
        hold_sink = 0;
        sink_busy = 0;
      end
      g = sink_busy ? 0 : gap_len();
      if (g > 0) begin
        m_axis_tready <= 0;
        repeat (g) @(negedge clk);
      end
      m_axis_tready <= 1;
      @(negedge clk);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_byte(logic [7:0] b, logic last, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // rule set used by every random phase: three byte alphabet so matches are common
  task automatic load_rules(logic [2:0] nr, logic [11:0] ml, logic [11:0] rl, logic [15:0] lim);
    logic [63:0] p[2];
    for (int i = 0; i < 2; i++)
      for (int k = 0; k < 8; k++) p[i][8*k +: 8] = 8'h40 + $urandom_range(0, 2);
    write_reg(REG_RULE_COUNT, {61'd0, nr});
    write_reg(REG_MATCH_LOW, p[0]);
    write_reg(REG_MATCH_HIGH, p[1]);
    write_reg(REG_REPL_LOW, {$urandom, $urandom});
    write_reg(REG_REPL_HIGH, {$urandom, $urandom});
    write_reg(REG_MATCH_LEN, {52'd0, ml});
    write_reg(REG_REPL_LEN, {52'd0, rl});
    write_reg(REG_DST_LIMIT, {48'd0, lim});
  endtask

  function automatic logic [11:0] rand_lens();
    logic [11:0] v;
    for (int r = 0; r < 4; r++)
      v[3*r +: 3] = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(1, 4));
    return v;
  endfunction

  initial begin
    int len;
    logic [7:0] b;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: single byte streams with no rules and zero capacity, then extremes
    send_byte(8'h00, 1, 0);
    send_byte(8'hff, 1, 0);
    drain();
    write_reg(REG_DST_LIMIT, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_RULE_COUNT, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_MATCH_LOW, 64'h4443_4241_0000_0000);
    write_reg(REG_MATCH_HIGH, 64'hffff_ffff_4141_4141);
    write_reg(REG_REPL_LOW, 64'haaaa_aaaa_5555_5555);
    write_reg(REG_REPL_HIGH, 64'h0000_0000_ffff_ffff);
    write_reg(REG_MATCH_LEN, 64'h0000_0000_0000_0ca0);
    write_reg(REG_REPL_LEN, 64'h0000_0000_0000_0fff);
    send_byte(8'h00, 0, 0);
    send_byte(8'h41, 0, 0);
    send_byte(8'h42, 0, 0);
    send_byte(8'h43, 0, 0);
    send_byte(8'h44, 0, 0);
    send_byte(8'h41, 0, 0);
    send_byte(8'h41, 0, 0);
    send_byte(8'h41, 0, 0);
    send_byte(8'h41, 0, 0);
    send_byte(8'hff, 0, 0);
    send_byte(8'hff, 1, 0);
    drain();
    // halt: capacity of three, trailing bytes ignored
    write_reg(REG_DST_LIMIT, 64'd3);
    for (int i = 0; i < 8; i++) send_byte(8'(i * 37), i == 7, 0);
    drain();

    // random streams under several rule sets
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_rules(3'd0, 12'hfff, 12'hfff, 16'hffff);
        1: load_rules(3'd7, rand_lens(), rand_lens(), 16'hffff);
        2: load_rules(3'd4, rand_lens(), rand_lens(), 16'd12);
        default: load_rules(3'($urandom_range(1, 5)), rand_lens(), rand_lens(),
                            16'($urandom_range(0, 40)));
      endcase
      for (int s = 0; s < 11; s++) begin
        len = $urandom_range(1, 10);
        if (phase == 1 && s == 0) begin
          hold_sink = 1;
          len = 30;
        end
        for (int i = 0; i < len; i++) begin
          b = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'h40 + $urandom_range(0, 2);
          send_byte(b, i == len - 1, hold_sink);
        end
      end
      drain();
    end

    while (hold_sink || sink_busy) @(negedge clk);
    drain();
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
